FILE: rtl/capped_dictionary_encoder_macros.svh
// Assertion macros used by the checker file of the dictionary encoder.
`ifndef CAPPED_DICTIONARY_ENCODER_MACROS_SVH
`define CAPPED_DICTIONARY_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define CDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and held off during reset.
`define CDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cde_pkg.sv
// Types, codes and default sizes shared by the dictionary encoder files.
package cde_pkg;

    localparam int CDE_DICT_DEPTH = 256;
    localparam int CDE_VALUE_BITS = 64;

    localparam int VALUE_W     = 64;
    localparam int CODE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int MIN_ROWS_W  = 20;
    localparam int MAX_ENT_W   = 9;
    localparam int COUNT_OUT_W = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ROWS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ENTRIES = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVF = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DIS = 2'd2;

    localparam logic [MAX_ENT_W-1:0] MAX_ENTRIES_RESET = 9'd256;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_row;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]      code_index;
        logic                   new_entry;
        logic [STATUS_W-1:0]    row_status;
        logic                   final_row;
        logic                   encoded;
        logic [COUNT_OUT_W-1:0] distinct_count;
    } out_item_t;

    typedef struct packed {
        logic kill;
        logic write;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } state_t;

endpackage

FILE: rtl/capped_dictionary_encoder.sv
// Top level of the capped dictionary encoder: control, counters and output register.
// The block takes one request at a time. A row seen while encoding is disabled, or
// after the column has overflowed, is resolved without a probe. Any other row sends
// a probe down the row of dictionary cells, one cell per cycle, and is resolved when
// the probe reaches the matching entry, or the end of the current dictionary when
// the value is new. A resolved result goes to a holding register and moves to the
// output register once the previous result there has been accepted. A finished
// result waits in the output register while the next request is already accepted.
// No clearing pass is needed after reset; the dictionary is emptied at the end of
// every column by resetting its size.
module capped_dictionary_encoder import cde_pkg::*; #(
    parameter int DICT_DEPTH = CDE_DICT_DEPTH,
    parameter int VALUE_BITS = CDE_VALUE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    localparam int IW = $clog2(DICT_DEPTH);
    localparam int CW = $clog2(DICT_DEPTH + 1);
    localparam int LW = (CW > MAX_ENT_W) ? CW : MAX_ENT_W;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          entry_reg, entry_next;
    logic                   ovf_reg, ovf_next;
    logic [MIN_ROWS_W-1:0]  row_reg, row_next;
    logic                   last_reg, last_next;
    out_item_t              res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    logic                   enable_reg;
    logic [MIN_ROWS_W-1:0]  min_rows_reg;
    logic [MAX_ENT_W-1:0]   max_entries_reg;

    logic [DICT_DEPTH-1:0]  match_vec;
    logic                   match_sel;
    logic [LW-1:0]          limit;
    logic                   room;
    logic                   inject;
    cell_ctrl_t             ctrl;
    logic                   resolve;
    logic [STATUS_W-1:0]    status;
    logic [CW-1:0]          code;
    logic                   append;
    logic                   ovf_set;
    logic                   last_src;
    logic [CW-1:0]          ec_after;
    logic                   ovf_after;
    logic [MIN_ROWS_W-1:0]  rc_inc;
    logic                   long_enough;

    cde_chain #(
        .DICT_DEPTH(DICT_DEPTH),
        .VALUE_BITS(VALUE_BITS)
    ) u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .inject_valid(inject),
        .inject_value(s_data.value[VALUE_BITS-1:0]),
        .ctrl        (ctrl),
        .match_vec   (match_vec)
    );

    assign match_sel = match_vec[pos_reg[IW-1:0]];
    assign limit     = (LW'(max_entries_reg) > LW'(DICT_DEPTH)) ? LW'(DICT_DEPTH)
                                                                : LW'(max_entries_reg);
    assign room      = LW'(entry_reg) < limit;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b1;
            min_rows_reg    <= '0;
            max_entries_reg <= MAX_ENTRIES_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENABLE: begin
                    enable_reg <= cfg_data[0];
                end
                CFG_MIN_ROWS: begin
                    min_rows_reg <= cfg_data[MIN_ROWS_W-1:0];
                end
                CFG_MAX_ENTRIES: begin
                    max_entries_reg <= cfg_data[MAX_ENT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            entry_reg   <= '0;
            ovf_reg     <= 1'b0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            entry_reg   <= entry_next;
            ovf_reg     <= ovf_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg   <= last_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        entry_next   = entry_reg;
        ovf_next     = ovf_reg;
        row_next     = row_reg;
        last_next    = last_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        inject       = 1'b0;
        ctrl         = '0;
        resolve      = 1'b0;
        status       = STAT_OK;
        code         = '0;
        append       = 1'b0;
        ovf_set      = 1'b0;
        last_src     = last_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    last_next = s_data.last_row;
                    last_src  = s_data.last_row;
                    if (!enable_reg) begin
                        resolve = 1'b1;
                        status  = STAT_DIS;
                    end else if (ovf_reg) begin
                        resolve = 1'b1;
                        status  = STAT_OVF;
                    end else begin
                        inject     = 1'b1;
                        pos_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (pos_reg == entry_reg) begin
                    ctrl.kill = 1'b1;
                    resolve   = 1'b1;
                    if (room) begin
                        append     = 1'b1;
                        ctrl.write = 1'b1;
                        code       = entry_reg;
                    end else begin
                        ovf_set = 1'b1;
                        status  = STAT_OVF;
                    end
                end else if (match_sel) begin
                    ctrl.kill = 1'b1;
                    resolve   = 1'b1;
                    code      = pos_reg;
                end else begin
                    pos_next = pos_reg + CW'(1);
                end
            end
            S_WAIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        ec_after    = entry_reg + CW'(append);
        ovf_after   = ovf_reg || ovf_set;
        rc_inc      = (row_reg == '1) ? row_reg : row_reg + MIN_ROWS_W'(1);
        long_enough = rc_inc >= min_rows_reg;

        if (resolve) begin
            res_next.code_index     = CODE_W'(code);
            res_next.new_entry      = append;
            res_next.row_status     = status;
            res_next.final_row      = last_src;
            res_next.encoded        = last_src && enable_reg && long_enough && !ovf_after;
            res_next.distinct_count = (last_src && enable_reg && long_enough)
                                      ? COUNT_OUT_W'(ec_after) : '0;
            state_next = S_WAIT;
            if (last_src) begin
                row_next   = '0;
                entry_next = '0;
                ovf_next   = 1'b0;
            end else begin
                row_next   = rc_inc;
                entry_next = ec_after;
                ovf_next   = ovf_after;
            end
        end
    end

endmodule

FILE: rtl/cde_cell.sv
// One dictionary cell: a stored value and the probe stage that passes through it.
module cde_cell import cde_pkg::*; #(
    parameter int VALUE_BITS = CDE_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  probe_valid_in,
    input  logic [VALUE_BITS-1:0] probe_value_in,
    input  cell_ctrl_t            ctrl,
    output logic                  probe_valid_out,
    output logic [VALUE_BITS-1:0] probe_value_out,
    output logic                  match
);

    logic                  probe_valid_reg;
    logic                  probe_valid_next;
    logic [VALUE_BITS-1:0] probe_value_reg;
    logic [VALUE_BITS-1:0] stored_reg;

    assign probe_valid_next = probe_valid_in && !ctrl.kill;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_valid_reg <= 1'b0;
        end else begin
            probe_valid_reg <= probe_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_value_reg <= probe_value_in;
        if (ctrl.write && probe_valid_reg) begin
            stored_reg <= probe_value_reg;
        end
    end

    assign match           = probe_valid_reg && (stored_reg == probe_value_reg);
    assign probe_valid_out = probe_valid_reg;
    assign probe_value_out = probe_value_reg;

endmodule

FILE: rtl/cde_chain.sv
// Row of dictionary cells; the probe moves one cell toward the tail each cycle.
module cde_chain import cde_pkg::*; #(
    parameter int DICT_DEPTH = CDE_DICT_DEPTH,
    parameter int VALUE_BITS = CDE_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  inject_valid,
    input  logic [VALUE_BITS-1:0] inject_value,
    input  cell_ctrl_t            ctrl,
    output logic [DICT_DEPTH-1:0] match_vec
);

    logic                  valid_link [DICT_DEPTH];
    logic [VALUE_BITS-1:0] value_link [DICT_DEPTH];

    assign valid_link[0] = inject_valid;
    assign value_link[0] = inject_value;

    for (genvar i = 0; i < DICT_DEPTH; i++) begin : g_cell
        if (i < DICT_DEPTH - 1) begin : g_mid
            cde_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .probe_valid_in (valid_link[i]),
                .probe_value_in (value_link[i]),
                .ctrl           (ctrl),
                .probe_valid_out(valid_link[i+1]),
                .probe_value_out(value_link[i+1]),
                .match          (match_vec[i])
            );
        end else begin : g_tail
            cde_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .probe_valid_in (valid_link[i]),
                .probe_value_in (value_link[i]),
                .ctrl           (ctrl),
                .probe_valid_out(),
                .probe_value_out(),
                .match          (match_vec[i])
            );
        end
    end

endmodule

FILE: rtl/cde_checker.sv
// Port-level checks for the capped dictionary encoder and their binding to it.
`include "capped_dictionary_encoder_macros.svh"

module cde_checker import cde_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_wr_en,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data,
    input logic                   s_valid,
    input logic                   s_ready,
    input in_item_t               s_data,
    input logic                   m_valid,
    input logic                   m_ready,
    input out_item_t              m_data
);

    `CDE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")
    `CDE_ASSERT_NOW(a_verdict_final, m_valid && !m_data.final_row, !m_data.encoded && (m_data.distinct_count == '0), "verdict on a row that is not final")
    `CDE_ASSERT_NOW(a_bad_status_code, m_valid && (m_data.row_status != STAT_OK), (m_data.code_index == '0) && !m_data.new_entry, "code given on a row that is not ok")
    `CDE_ASSERT_NOW(a_encoded_ok, m_valid && m_data.encoded, m_data.final_row && (m_data.row_status == STAT_OK), "encoded verdict on an overflowed or disabled row")

endmodule

bind capped_dictionary_encoder cde_checker u_cde_checker (.*);
